@@ src/apsq_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apsq_pkg
// Shared types and constants for the audio block power squelch core.
// ---------------------------------------------------------------------------
package apsq_pkg;

  // sample and accumulator widths
  localparam int SAMPLE_W = 16;
  localparam int MIX_W    = 16;
  localparam int SQ_W     = 31;
  localparam int POWER_W  = 41;
  localparam int COUNT_W  = 10;
  localparam int LEVEL_W  = 4;

  // block length default, range 1 to 2**COUNT_W
  localparam int BLOCK_SIZE_DEFAULT = 1024;

  // threshold reset values (about -46 dB and -41 dB of block full scale)
  localparam logic [POWER_W-1:0] LOW_THRESHOLD_RESET  = POWER_W'(27163759);
  localparam logic [POWER_W-1:0] HIGH_THRESHOLD_RESET = POWER_W'(85899345);

  // hysteresis steps
  localparam logic [LEVEL_W-1:0] LEVEL_DOWN_STEP = LEVEL_W'(1);
  localparam logic [LEVEL_W-1:0] LEVEL_UP_STEP   = LEVEL_W'(3);
  localparam logic [LEVEL_W-1:0] LEVEL_UP_LIMIT  = LEVEL_W'(10);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX       = LEVEL_W'(12);

  // configuration register map
  localparam int CFG_INDEX_W = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LOW_THRESHOLD  = CFG_INDEX_W'(0),
    CFG_HIGH_THRESHOLD = CFG_INDEX_W'(1)
  } cfg_reg_t;

  // input word: one stereo sample pair
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } in_word_t;

  // output word: mono mix and squelch status
  typedef struct packed {
    logic signed [MIX_W-1:0] mixed_sample;
    logic                    block_end;
    logic [POWER_W-1:0]      block_power;
    logic [LEVEL_W-1:0]      squelch_level;
    logic                    muted;
  } out_word_t;

endpackage

@@ src/apsq_mix_square.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apsq_mix_square
// Mono mix of a stereo pair and its square, held in one pipeline register.
// ---------------------------------------------------------------------------
module apsq_mix_square (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic                                in_valid,
  input  apsq_pkg::in_word_t                  in_data,
  output logic                                mix_valid,
  output logic signed [apsq_pkg::MIX_W-1:0]   mix,
  output logic        [apsq_pkg::SQ_W-1:0]    mix_square
);
  import apsq_pkg::*;

  logic signed [MIX_W-1:0]   half_left;
  logic signed [MIX_W-1:0]   half_right;
  logic signed [MIX_W-1:0]   mix_comb;
  logic signed [2*MIX_W-1:0] square_full;

  // halve each channel then add; the sum cannot overflow
  always_comb begin
    half_left   = in_data.left_sample >>> 1;
    half_right  = in_data.right_sample >>> 1;
    mix_comb    = half_left + half_right;
    square_full = mix_comb * mix_comb;
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (advance) begin
      mix_valid <= in_valid;
    end
  end

  // payload, square is never negative and at most 2**30
  always_ff @(posedge clk) begin
    if (advance) begin
      mix        <= mix_comb;
      mix_square <= square_full[SQ_W-1:0];
    end
  end

endmodule

@@ src/audio_block_power_squelch_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// audio_block_power_squelch_core
// Stereo to mono mix with block power measurement and squelch hysteresis.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | word
//  in      | input     | in_valid / in_stall | left_sample, right_sample
//  out     | output    | out_valid/out_stall | mix, block end, power, level, muted
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (41 bit)
//
//  One word is taken per cycle unless out stalls; a result passes three pipeline
//  registers (input, mix and square, accumulate and output) before it leaves.
//  The square and the 41-bit accumulate each sit in a stage of their own.
//  rst is synchronous: counter, accumulator, level and thresholds return to
//  their reset values. A stall on out while out_valid is high freezes the whole
//  pipeline and is seen on in_stall in the same cycle. cfg_ready is always high.
// ---------------------------------------------------------------------------
module audio_block_power_squelch_core #(
  parameter int BLOCK_SIZE = apsq_pkg::BLOCK_SIZE_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  apsq_pkg::in_word_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output apsq_pkg::out_word_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [apsq_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [apsq_pkg::POWER_W-1:0]          cfg_data
);
  import apsq_pkg::*;

  localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(BLOCK_SIZE - 1);

  // pipeline control
  logic advance;

  // input register
  logic     in_valid_q;
  in_word_t in_q;

  // mix stage
  logic                    mix_valid;
  logic signed [MIX_W-1:0] mix;
  logic [SQ_W-1:0]         mix_square;

  // thresholds
  logic [POWER_W-1:0] low_threshold;
  logic [POWER_W-1:0] high_threshold;

  // block state and output register
  logic [COUNT_W-1:0]      sample_count;
  logic [POWER_W-1:0]      power_sum;
  logic [LEVEL_W-1:0]      level;
  logic [POWER_W-1:0]      last_block_power;
  logic signed [MIX_W-1:0] out_mix;
  logic                    out_end;

  logic [POWER_W-1:0] power_sum_next;
  logic [LEVEL_W-1:0] level_next;
  logic               block_done;

  // whole pipeline moves unless a held result is stalled
  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;
  assign cfg_ready = 1'b1;

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= LOW_THRESHOLD_RESET;
      high_threshold <= HIGH_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
        CFG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (advance) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_q <= in_data;
    end
  end

  apsq_mix_square u_mix_square (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (in_valid_q),
    .in_data    (in_q),
    .mix_valid  (mix_valid),
    .mix        (mix),
    .mix_square (mix_square)
  );

  // accumulate and hysteresis update, decrease takes priority
  always_comb begin
    power_sum_next = power_sum + {{(POWER_W-SQ_W){1'b0}}, mix_square};
    block_done     = (sample_count == LAST_COUNT);
    level_next     = level;
    if (power_sum_next < low_threshold && level != '0) begin
      level_next = level - LEVEL_DOWN_STEP;
    end else if (power_sum_next > high_threshold && level < LEVEL_UP_LIMIT) begin
      level_next = level + LEVEL_UP_STEP;
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      sample_count     <= '0;
      power_sum        <= '0;
      level            <= '0;
      last_block_power <= '0;
    end else if (advance) begin
      out_valid <= mix_valid;
      if (mix_valid) begin
        if (block_done) begin
          sample_count     <= '0;
          power_sum        <= '0;
          level            <= level_next;
          last_block_power <= power_sum_next;
        end else begin
          sample_count <= sample_count + COUNT_W'(1);
          power_sum    <= power_sum_next;
        end
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (advance && mix_valid) begin
      out_mix <= mix;
      out_end <= block_done;
    end
  end

  // output word
  always_comb begin
    out_data.mixed_sample  = out_mix;
    out_data.block_end     = out_end;
    out_data.block_power   = last_block_power;
    out_data.squelch_level = level;
    out_data.muted         = (level == '0);
  end

`ifndef SYNTHESIS
  // a block end result always leaves the counter at the start of a block
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.block_end) |-> (sample_count == '0))
    else $error("block end shown with counter not cleared");

  // level never goes past its peak
  assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_MAX)
    else $error("squelch level beyond peak");

  // level only moves with a block end result
  assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && level != $past(level)) |-> (out_valid && out_data.block_end))
    else $error("squelch level changed outside block end");

  // counter stays inside the block
  assert property (@(posedge clk) disable iff (rst)
    sample_count <= LAST_COUNT)
    else $error("sample counter beyond block length");
`endif

endmodule
